FILE: sv/pbd_distance_constraint_solve_unit_assert.svh
// Assertion macros shared by the solver RTL.
`ifndef PBD_DISTANCE_CONSTRAINT_SOLVE_UNIT_ASSERT_SVH
`define PBD_DISTANCE_CONSTRAINT_SOLVE_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define PBDCS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define PBDCS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: sv/pbdcs_pkg.sv
`default_nettype none
package pbdcs_pkg;

	localparam int DEF_VERTEX_COUNT = 1024;
	localparam int DEF_FRAC_BITS    = 16;

	localparam int IDX_W       = 10;
	localparam int POS_W       = 32;
	localparam int MASS_W      = 32;
	localparam int LEN_W       = 31;
	localparam int STIFF_W     = 16;
	localparam int ACC_W       = 32;
	localparam int DIFF_W      = 33;
	localparam int Q_W         = 30;
	localparam int SSUM_W      = 62;
	localparam int ROOT_W      = 31;
	localparam int DIST_W      = 34;
	localparam int DELTA_W     = 35;
	localparam int MUL_A_W     = 35;
	localparam int MUL_B_W     = 30;
	localparam int MUL_P_W     = MUL_A_W + MUL_B_W;
	localparam int DIV_DVD_W   = 64;
	localparam int DIV_DSR_W   = 33;
	localparam int DIV_QW      = 34;
	localparam int DIV_CNT_W   = 6;
	localparam int SQ_W        = 64;
	localparam int CFG_IDX_W   = 8;
	localparam int IN_TDATA_W  = 312;
	localparam int OUT_TDATA_W = 112;

	localparam logic [STIFF_W-1:0] STRETCH_RST  = 16'd3277;
	localparam logic [STIFF_W-1:0] COMPRESS_RST = 16'd0;

	localparam logic [CFG_IDX_W-1:0] CFG_STRETCH  = 8'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_COMPRESS = 8'd1;

	localparam logic CMD_SOLVE = 1'b0;
	localparam logic CMD_CLEAR = 1'b1;

	typedef struct packed {
		logic                         clr;
		logic                         last;
		logic [IDX_W-1:0]             idx;
		logic [2:0][DELTA_W-1:0]      delta;
	} acc_req_t;

endpackage
`default_nettype wire

FILE: sv/pbdcs_isqrt.sv
`default_nettype none
module pbdcs_isqrt (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          start,
	input  wire  [pbdcs_pkg::SSUM_W-1:0] radicand,
	output logic                         done,
	output logic [pbdcs_pkg::ROOT_W-1:0] root
);
	import pbdcs_pkg::*;

	logic            busy_q;
	logic            done_q;
	logic [SQ_W-1:0] n_q;
	logic [SQ_W-1:0] r_q;
	logic [SQ_W-1:0] bit_q;
	logic [SQ_W-1:0] trial;

	assign trial = r_q + bit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q && bit_q[0]) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	// two radicand bits per cycle, lowest pair finishes
	always_ff @(posedge clk) begin
		if (start) begin
			n_q   <= SQ_W'(radicand);
			r_q   <= '0;
			bit_q <= SQ_W'(1) << (SQ_W - 2);
		end else if (busy_q) begin
			if (n_q >= trial) begin
				n_q <= n_q - trial;
				r_q <= (r_q >> 1) + bit_q;
			end else begin
				r_q <= r_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

	assign done = done_q;
	assign root = r_q[ROOT_W-1:0];

endmodule
`default_nettype wire

FILE: sv/pbdcs_div.sv
`default_nettype none
module pbdcs_div (
	input  wire                             clk,
	input  wire                             arst_n,
	input  wire                             start,
	input  wire  [pbdcs_pkg::DIV_DVD_W-1:0] dividend,
	input  wire  [pbdcs_pkg::DIV_DSR_W-1:0] divisor,
	input  wire  [pbdcs_pkg::DIV_CNT_W-1:0] nbits,
	output logic                            done,
	output logic [pbdcs_pkg::DIV_QW-1:0]    quotient
);
	import pbdcs_pkg::*;

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [DIV_DSR_W-1:0] rem_q;
	logic [DIV_DSR_W-1:0] dsr_q;
	logic [DIV_DVD_W-1:0] sh_q;
	logic [DIV_QW-1:0]    quo_q;
	logic [DIV_DSR_W+1:0] diff;
	logic                 qbit;

	// quotient fits in nbits bits, so the top of the dividend seeds the remainder
	assign diff = {1'b0, rem_q, sh_q[DIV_DVD_W-1]} - {2'b00, dsr_q};
	assign qbit = ~diff[DIV_DSR_W+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= nbits;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DIV_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= DIV_DSR_W'(dividend >> nbits);
			sh_q  <= dividend << (7'(DIV_DVD_W) - 7'(nbits));
			dsr_q <= divisor;
			quo_q <= '0;
		end else if (busy_q) begin
			if (qbit) begin
				rem_q <= diff[DIV_DSR_W-1:0];
			end else begin
				rem_q <= {rem_q[DIV_DSR_W-2:0], sh_q[DIV_DVD_W-1]};
			end
			sh_q  <= sh_q << 1;
			quo_q <= {quo_q[DIV_QW-2:0], qbit};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule
`default_nettype wire

FILE: sv/pbdcs_acc.sv
`default_nettype none
module pbdcs_acc #(
	parameter int VERTEX_COUNT = pbdcs_pkg::DEF_VERTEX_COUNT
) (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire                               req_valid,
	input  pbdcs_pkg::acc_req_t               req,
	output logic                              req_ready,
	output logic                              init_busy,
	output logic                              m_tvalid,
	input  wire                               m_tready,
	output logic [pbdcs_pkg::OUT_TDATA_W-1:0] m_tdata,
	output logic                              m_tlast
);
	import pbdcs_pkg::*;

	localparam int AW    = (VERTEX_COUNT > 1) ? $clog2(VERTEX_COUNT) : 1;
	localparam int EXT_W = IDX_W + AW;
	localparam int ROW_W = 3 * ACC_W;

	logic [ROW_W-1:0] mem [VERTEX_COUNT];

	logic             init_q;
	logic [AW-1:0]    clr_cnt_q;
	logic             busy_s1;
	acc_req_t         req_s1;
	logic             in_rng_s1;
	logic [AW-1:0]    addr_s1;
	logic [ROW_W-1:0] rd_q;
	logic             out_vld_q;
	logic [IDX_W-1:0] out_idx_q;
	logic [ROW_W-1:0] out_acc_q;
	logic             out_last_q;

	logic [EXT_W-1:0] req_ext;
	logic [AW-1:0]    req_addr;
	logic             req_in_rng;
	logic             req_fire;
	logic [ROW_W-1:0] new_row;

	function automatic logic [ACC_W-1:0] sat_add(input logic [ACC_W-1:0] acc,
		input logic [DELTA_W-1:0] dl);
		logic [DELTA_W:0] sum;
		sum = {{(DELTA_W+1-ACC_W){acc[ACC_W-1]}}, acc} + {dl[DELTA_W-1], dl};
		if (sum[DELTA_W:ACC_W-1] == '0 || sum[DELTA_W:ACC_W-1] == '1) begin
			sat_add = sum[ACC_W-1:0];
		end else begin
			sat_add = sum[DELTA_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
		end
	endfunction

	assign req_ext    = {{AW{1'b0}}, req.idx};
	assign req_addr   = req_ext[AW-1:0];
	assign req_in_rng = req_ext < EXT_W'(VERTEX_COUNT);
	assign req_ready  = !init_q && !busy_s1 && !out_vld_q;
	assign req_fire   = req_valid && req_ready;

	always_comb begin
		for (int a = 0; a < 3; a++) begin
			if (req_s1.clr) begin
				new_row[a*ACC_W +: ACC_W] = '0;
			end else begin
				new_row[a*ACC_W +: ACC_W] = sat_add(rd_q[a*ACC_W +: ACC_W], req_s1.delta[a]);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_q    <= 1'b1;
			clr_cnt_q <= '0;
			busy_s1   <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (init_q) begin
				clr_cnt_q <= clr_cnt_q + 1'b1;
				if (clr_cnt_q == AW'(VERTEX_COUNT - 1)) begin
					init_q <= 1'b0;
				end
			end
			if (req_fire) begin
				busy_s1 <= 1'b1;
			end else if (busy_s1) begin
				busy_s1 <= 1'b0;
			end
			if (busy_s1) begin
				out_vld_q <= 1'b1;
			end else if (m_tready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	// read on accept, modify and write back in the following cycle
	always_ff @(posedge clk) begin
		if (init_q) begin
			mem[clr_cnt_q] <= '0;
		end else if (busy_s1 && in_rng_s1) begin
			mem[addr_s1] <= new_row;
		end
		if (req_fire) begin
			rd_q <= mem[req_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (req_fire) begin
			req_s1    <= req;
			in_rng_s1 <= req_in_rng;
			addr_s1   <= req_addr;
		end
		if (busy_s1) begin
			out_idx_q  <= req_s1.idx;
			out_acc_q  <= in_rng_s1 ? new_row : '0;
			out_last_q <= req_s1.last;
		end
	end

	assign init_busy = init_q;
	assign m_tvalid  = out_vld_q;
	assign m_tdata   = {{(OUT_TDATA_W-IDX_W-ROW_W){1'b0}}, out_acc_q, out_idx_q};
	assign m_tlast   = out_last_q;

endmodule
`default_nettype wire

FILE: sv/pbd_distance_constraint_solve_unit.sv
// One item in flight at a time. Solve items run the square root and then the shared restoring
// divider (one quotient bit per cycle, eight divisions per item when the distance is nonzero).
// Results wait in an output register. After reset the accumulator memory is swept to zero
// with s_tready low; stiffness registers reset to 3277 and 0.
`default_nettype none
`include "pbd_distance_constraint_solve_unit_assert.svh"
module pbd_distance_constraint_solve_unit #(
	parameter int VERTEX_COUNT = pbdcs_pkg::DEF_VERTEX_COUNT,
	parameter int FRAC_BITS    = pbdcs_pkg::DEF_FRAC_BITS
) (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire                               cfg_valid,
	output logic                              cfg_ready,
	input  wire  [pbdcs_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire  [pbdcs_pkg::STIFF_W-1:0]     cfg_data,
	input  wire                               s_tvalid,
	output logic                              s_tready,
	// pos_a_x, pos_a_y, pos_a_z, pos_b_x, pos_b_y, pos_b_z, inv_mass_a, inv_mass_b,
	// rest_length, vertex_a, vertex_b, zero fill
	input  wire  [pbdcs_pkg::IN_TDATA_W-1:0]  s_tdata,
	// cmd
	input  wire  [0:0]                        s_tuser,
	output logic                              m_tvalid,
	input  wire                               m_tready,
	// vertex_index, acc_x, acc_y, acc_z, zero fill
	output logic [pbdcs_pkg::OUT_TDATA_W-1:0] m_tdata,
	output logic                              m_tlast
);
	import pbdcs_pkg::*;

	localparam int RW = FRAC_BITS + 1;

	localparam logic [4:0] ST_IDLE = 5'd0;
	localparam logic [4:0] ST_PREP = 5'd1;
	localparam logic [4:0] ST_SQX  = 5'd2;
	localparam logic [4:0] ST_SQY  = 5'd3;
	localparam logic [4:0] ST_SQZ  = 5'd4;
	localparam logic [4:0] ST_SQE  = 5'd5;
	localparam logic [4:0] ST_SQRT = 5'd6;
	localparam logic [4:0] ST_ERR  = 5'd7;
	localparam logic [4:0] ST_G    = 5'd8;
	localparam logic [4:0] ST_GW   = 5'd9;
	localparam logic [4:0] ST_DIVA = 5'd10;
	localparam logic [4:0] ST_DIVB = 5'd11;
	localparam logic [4:0] ST_TA   = 5'd12;
	localparam logic [4:0] ST_TB   = 5'd13;
	localparam logic [4:0] ST_TBW  = 5'd14;
	localparam logic [4:0] ST_CM   = 5'd15;
	localparam logic [4:0] ST_CD   = 5'd16;
	localparam logic [4:0] ST_UPDA = 5'd17;
	localparam logic [4:0] ST_UPDB = 5'd18;
	localparam logic [4:0] ST_CLR  = 5'd19;

	logic [4:0]          state_q;
	logic                run_q;
	logic                side_q;
	logic [1:0]          axis_q;
	logic [STIFF_W-1:0]  stretch_q;
	logic [STIFF_W-1:0]  compress_q;

	logic [POS_W-1:0]    pa_q [3];
	logic [POS_W-1:0]    pb_q [3];
	logic [MASS_W-1:0]   ima_q;
	logic [MASS_W-1:0]   imb_q;
	logic [LEN_W-1:0]    len_q;
	logic [IDX_W-1:0]    va_q;
	logic [IDX_W-1:0]    vb_q;
	logic [Q_W-1:0]      q_q [3];
	logic [2:0]          neg_q;
	logic [1:0]          s_q;
	logic [MASS_W-1:0]   wa_q;
	logic [MASS_W-1:0]   wb_q;
	logic [MASS_W:0]     wsum_q;
	logic [MUL_P_W-1:0]  prod_q;
	logic [SSUM_W-1:0]   ssum_q;
	logic [ROOT_W-1:0]   dq_q;
	logic                eneg_q;
	logic [DIST_W-1:0]   emag_q;
	logic [STIFF_W-1:0]  k_q;
	logic [DIST_W-1:0]   g_q;
	logic [RW-1:0]       ra_q;
	logic [RW-1:0]       rb_q;
	logic [DIST_W-1:0]   ta_q;
	logic [DIST_W-1:0]   tb_q;
	logic [1:0][2:0][DELTA_W-1:0] delta_q;

	logic                in_fire;
	logic [MUL_A_W-1:0]  mul_a;
	logic [MUL_B_W-1:0]  mul_b;
	logic [MUL_P_W-1:0]  mul_p;
	logic                sqrt_start;
	logic                sqrt_done;
	logic [ROOT_W-1:0]   sqrt_root;
	logic                div_state;
	logic                div_start;
	logic                div_done;
	logic [DIV_DVD_W-1:0] div_dvd;
	logic [DIV_DSR_W-1:0] div_dsr;
	logic [DIV_CNT_W-1:0] div_nb;
	logic [DIV_QW-1:0]   div_quo;
	logic                acc_req_valid;
	logic                acc_req_ready;
	logic                acc_init;
	acc_req_t            acc_req;

	logic [DIFF_W-1:0]   diff [3];
	logic [DIFF_W-1:0]   absd [3];
	logic [2:0]          top_bits [3];
	logic [1:0]          shift;
	logic [MASS_W-1:0]   wa_eff;
	logic [MASS_W-1:0]   wb_eff;
	logic [MASS_W:0]     wsum_raw;
	logic [DIST_W-1:0]   dist_val;
	logic                eneg;
	logic                c_neg;
	logic [DELTA_W-1:0]  c_ext;

	assign in_fire   = s_tvalid && s_tready;
	assign s_tready  = (state_q == ST_IDLE) && !acc_init;
	assign cfg_ready = 1'b1;

	// axis differences, magnitudes and the common pre-shift; effective weights, distance and signs
	always_comb begin
		for (int a = 0; a < 3; a++) begin
			diff[a]     = {pa_q[a][POS_W-1], pa_q[a]} - {pb_q[a][POS_W-1], pb_q[a]};
			absd[a]     = diff[a][DIFF_W-1] ? (~diff[a] + 1'b1) : diff[a];
			top_bits[a] = absd[a][DIFF_W-1:DIFF_W-3];
		end
		if (top_bits[0][2] || top_bits[1][2] || top_bits[2][2]) begin
			shift = 2'd3;
		end else if (top_bits[0][1] || top_bits[1][1] || top_bits[2][1]) begin
			shift = 2'd2;
		end else if (top_bits[0][0] || top_bits[1][0] || top_bits[2][0]) begin
			shift = 2'd1;
		end else begin
			shift = 2'd0;
		end
		wa_eff   = (ima_q == '1) ? '0 : ima_q;
		wb_eff   = (imb_q == '1) ? '0 : imb_q;
		wsum_raw = {1'b0, wa_eff} + {1'b0, wb_eff};
		dist_val = DIST_W'(dq_q) << s_q;
		eneg     = dist_val < DIST_W'(len_q);
		c_neg    = side_q ? (eneg_q != neg_q[axis_q]) : (eneg_q == neg_q[axis_q]);
		c_ext    = {1'b0, div_quo};
	end

	always_comb begin
		case (state_q)
			ST_SQX: begin
				mul_a = MUL_A_W'(q_q[0]);
				mul_b = q_q[0];
			end
			ST_SQY: begin
				mul_a = MUL_A_W'(q_q[1]);
				mul_b = q_q[1];
			end
			ST_SQZ: begin
				mul_a = MUL_A_W'(q_q[2]);
				mul_b = q_q[2];
			end
			ST_G: begin
				mul_a = MUL_A_W'(emag_q);
				mul_b = MUL_B_W'(k_q);
			end
			ST_TA: begin
				mul_a = MUL_A_W'(g_q);
				mul_b = MUL_B_W'(ra_q);
			end
			ST_TB: begin
				mul_a = MUL_A_W'(g_q);
				mul_b = MUL_B_W'(rb_q);
			end
			ST_CM: begin
				mul_a = MUL_A_W'(side_q ? tb_q : ta_q);
				mul_b = q_q[axis_q];
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_p = mul_a * mul_b;

	always_comb begin
		case (state_q)
			ST_DIVA: begin
				div_dvd = DIV_DVD_W'(wa_q) << FRAC_BITS;
				div_dsr = wsum_q;
				div_nb  = DIV_CNT_W'(RW);
			end
			ST_DIVB: begin
				div_dvd = DIV_DVD_W'(wb_q) << FRAC_BITS;
				div_dsr = wsum_q;
				div_nb  = DIV_CNT_W'(RW);
			end
			default: begin
				div_dvd = prod_q[DIV_DVD_W-1:0];
				div_dsr = DIV_DSR_W'(dq_q);
				div_nb  = DIV_CNT_W'(DIV_QW);
			end
		endcase
	end

	assign div_state  = (state_q == ST_DIVA) || (state_q == ST_DIVB) || (state_q == ST_CD);
	assign div_start  = div_state && !run_q;
	assign sqrt_start = (state_q == ST_SQRT) && !run_q;

	always_comb begin
		acc_req_valid = (state_q == ST_UPDA) || (state_q == ST_UPDB) || (state_q == ST_CLR);
		acc_req.clr   = (state_q == ST_CLR);
		acc_req.last  = (state_q != ST_UPDA);
		acc_req.idx   = (state_q == ST_UPDB) ? vb_q : va_q;
		acc_req.delta = delta_q[state_q == ST_UPDB];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			run_q      <= 1'b0;
			side_q     <= 1'b0;
			axis_q     <= 2'd0;
			stretch_q  <= STRETCH_RST;
			compress_q <= COMPRESS_RST;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_STRETCH:  stretch_q  <= cfg_data;
					CFG_COMPRESS: compress_q <= cfg_data;
					default: ;
				endcase
			end
			if (sqrt_start || div_start) begin
				run_q <= 1'b1;
			end else if (sqrt_done || div_done) begin
				run_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						state_q <= (s_tuser[0] == CMD_CLEAR) ? ST_CLR : ST_PREP;
					end
				end
				ST_PREP: state_q <= ST_SQX;
				ST_SQX:  state_q <= ST_SQY;
				ST_SQY:  state_q <= ST_SQZ;
				ST_SQZ:  state_q <= ST_SQE;
				ST_SQE:  state_q <= ST_SQRT;
				ST_SQRT: begin
					if (sqrt_done) begin
						state_q <= ST_ERR;
					end
				end
				ST_ERR:  state_q <= (dq_q == '0) ? ST_UPDA : ST_G;
				ST_G:    state_q <= ST_GW;
				ST_GW:   state_q <= ST_DIVA;
				ST_DIVA: begin
					if (div_done) begin
						state_q <= ST_DIVB;
					end
				end
				ST_DIVB: begin
					if (div_done) begin
						state_q <= ST_TA;
					end
				end
				ST_TA:   state_q <= ST_TB;
				ST_TB:   state_q <= ST_TBW;
				ST_TBW: begin
					side_q  <= 1'b0;
					axis_q  <= 2'd0;
					state_q <= ST_CM;
				end
				ST_CM:   state_q <= ST_CD;
				ST_CD: begin
					if (div_done) begin
						if (axis_q == 2'd2) begin
							axis_q  <= 2'd0;
							side_q  <= 1'b1;
							state_q <= side_q ? ST_UPDA : ST_CM;
						end else begin
							axis_q  <= axis_q + 1'b1;
							state_q <= ST_CM;
						end
					end
				end
				ST_UPDA: begin
					if (acc_req_ready) begin
						state_q <= ST_UPDB;
					end
				end
				ST_UPDB, ST_CLR: begin
					if (acc_req_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_p;
		if (in_fire) begin
			for (int a = 0; a < 3; a++) begin
				pa_q[a] <= s_tdata[a*POS_W +: POS_W];
				pb_q[a] <= s_tdata[(a+3)*POS_W +: POS_W];
			end
			ima_q <= s_tdata[6*POS_W +: MASS_W];
			imb_q <= s_tdata[6*POS_W+MASS_W +: MASS_W];
			len_q <= s_tdata[6*POS_W+2*MASS_W +: LEN_W];
			va_q  <= s_tdata[6*POS_W+2*MASS_W+LEN_W +: IDX_W];
			vb_q  <= s_tdata[6*POS_W+2*MASS_W+LEN_W+IDX_W +: IDX_W];
		end
		case (state_q)
			ST_PREP: begin
				for (int a = 0; a < 3; a++) begin
					q_q[a]   <= Q_W'(absd[a] >> shift);
					neg_q[a] <= diff[a][DIFF_W-1];
				end
				s_q     <= shift;
				wa_q    <= wa_eff;
				wb_q    <= wb_eff;
				wsum_q  <= (wsum_raw == '0) ? (MASS_W+1)'(1) : wsum_raw;
				delta_q <= '0;
			end
			ST_SQY: ssum_q <= SSUM_W'(prod_q);
			ST_SQZ, ST_SQE: ssum_q <= ssum_q + SSUM_W'(prod_q);
			ST_SQRT: begin
				if (sqrt_done) begin
					dq_q <= sqrt_root;
				end
			end
			ST_ERR: begin
				eneg_q <= eneg;
				emag_q <= eneg ? (DIST_W'(len_q) - dist_val) : (dist_val - DIST_W'(len_q));
				k_q    <= eneg ? compress_q : stretch_q;
			end
			ST_GW: g_q <= prod_q[STIFF_W +: DIST_W];
			ST_DIVA: begin
				if (div_done) begin
					ra_q <= div_quo[RW-1:0];
				end
			end
			ST_DIVB: begin
				if (div_done) begin
					rb_q <= div_quo[RW-1:0];
				end
			end
			ST_TB:  ta_q <= DIST_W'(prod_q >> FRAC_BITS);
			ST_TBW: tb_q <= DIST_W'(prod_q >> FRAC_BITS);
			ST_CD: begin
				if (div_done) begin
					delta_q[side_q][axis_q] <= c_neg ? (~c_ext + 1'b1) : c_ext;
				end
			end
			default: ;
		endcase
	end

	pbdcs_isqrt u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sqrt_start),
		.radicand (ssum_q),
		.done     (sqrt_done),
		.root     (sqrt_root)
	);

	pbdcs_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dvd),
		.divisor  (div_dsr),
		.nbits    (div_nb),
		.done     (div_done),
		.quotient (div_quo)
	);

	pbdcs_acc #(
		.VERTEX_COUNT (VERTEX_COUNT)
	) u_acc (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (acc_req_valid),
		.req       (acc_req),
		.req_ready (acc_req_ready),
		.init_busy (acc_init),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

	`PBDCS_ASSERT_NOW(a_div_done_in_div_state, div_done, div_state, "divider finished outside a divide step")
	`PBDCS_ASSERT_NOW(a_sqrt_done_in_sqrt, sqrt_done, state_q == ST_SQRT, "square root finished outside its step")
	`PBDCS_ASSERT_NEXT(a_upda_then_updb, (state_q == ST_UPDA) && acc_req_ready, state_q == ST_UPDB, "B update did not follow A update")
	`PBDCS_ASSERT_NEXT(a_accept_starts_work, in_fire, (state_q == ST_PREP) || (state_q == ST_CLR), "accepted transaction not started")

endmodule
`default_nettype wire

FILE: sim/tb_top.sv
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
	import pbdcs_pkg::*;

	localparam int NVERT      = DEF_VERTEX_COUNT;
	localparam int FB         = DEF_FRAC_BITS;
	localparam int IDLE_WAIT  = 400;
	localparam int WDOG_LIMIT = 20000;
	localparam int LONG_HOLD  = 3000;

	typedef struct {
		bit               cmd;
		bit [POS_W-1:0]   pa [3];
		bit [POS_W-1:0]   pb [3];
		bit [MASS_W-1:0]  ima;
		bit [MASS_W-1:0]  imb;
		bit [LEN_W-1:0]   rest;
		bit [IDX_W-1:0]   va;
		bit [IDX_W-1:0]   vb;
	} constraint_item_t;

	typedef struct packed {
		bit [IDX_W-1:0] idx;
		bit [ACC_W-1:0] ax;
		bit [ACC_W-1:0] ay;
		bit [ACC_W-1:0] az;
		bit             last;
	} acc_update_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [STIFF_W-1:0] cfg_data = '0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [IN_TDATA_W-1:0] s_tdata = '0;
	logic [0:0] s_tuser = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic m_tlast;

	pbd_distance_constraint_solve_unit dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// shadow of the accumulator memory and stiffness registers
	bit [ACC_W-1:0] sum_x [NVERT];
	bit [ACC_W-1:0] sum_y [NVERT];
	bit [ACC_W-1:0] sum_z [NVERT];
	bit [STIFF_W-1:0] k_stretch = STRETCH_RST;
	bit [STIFF_W-1:0] k_compress = COMPRESS_RST;

	acc_update_t pending_updates [$];
	int mismatches = 0;
	int burst_left = 0;
	bit hold_req = 1'b0;
	int wdog = 0;

	function automatic bit [63:0] int_sqrt(bit [63:0] n);
		bit [63:0] r;
		bit [63:0] b;
		r = 0;
		b = 64'd1 << 62;
		while (b > n) b = b >> 2;
		while (b != 0) begin
			if (n >= r + b) begin
				n = n - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	function automatic bit [ACC_W-1:0] sat_accumulate(bit [ACC_W-1:0] acc, longint d);
		longint s;
		s = longint'($signed(acc)) + d;
		if (s > 64'sd2147483647) s = 64'sd2147483647;
		if (s < -64'sd2147483648) s = -64'sd2147483648;
		return s[31:0];
	endfunction

	function automatic void add_correction(bit [IDX_W-1:0] idx, longint dv [3], bit last);
		acc_update_t u;
		sum_x[idx] = sat_accumulate(sum_x[idx], dv[0]);
		sum_y[idx] = sat_accumulate(sum_y[idx], dv[1]);
		sum_z[idx] = sat_accumulate(sum_z[idx], dv[2]);
		u.idx = idx;
		u.ax = sum_x[idx];
		u.ay = sum_y[idx];
		u.az = sum_z[idx];
		u.last = last;
		pending_updates.push_back(u);
	endfunction

	function automatic void predict_corrections(constraint_item_t it);
		bit [63:0] q [3];
		bit neg [3];
		longint da [3];
		longint db [3];
		longint d;
		bit [63:0] m, ssum, dq, dist_val, len, wa, wb, wsum, kk, emag, g, ra, rb, ta, tb, ca, cb;
		bit eneg;
		int s;
		acc_update_t u;
		if (it.cmd == CMD_CLEAR) begin
			sum_x[it.va] = 0;
			sum_y[it.va] = 0;
			sum_z[it.va] = 0;
			u = '{idx: it.va, ax: 0, ay: 0, az: 0, last: 1'b1};
			pending_updates.push_back(u);
			return;
		end
		m = 0;
		for (int i = 0; i < 3; i++) begin
			d = longint'($signed(it.pa[i])) - longint'($signed(it.pb[i]));
			neg[i] = d < 0;
			q[i] = neg[i] ? -d : d;
			if (q[i] > m) m = q[i];
			da[i] = 0;
			db[i] = 0;
		end
		s = 0;
		while ((m >> s) >= (64'd1 << 30)) s++;
		ssum = 0;
		for (int i = 0; i < 3; i++) begin
			q[i] = q[i] >> s;
			ssum += q[i] * q[i];
		end
		dq = int_sqrt(ssum);
		dist_val = dq << s;
		len = it.rest;
		wa = (it.ima == '1) ? 0 : it.ima;
		wb = (it.imb == '1) ? 0 : it.imb;
		wsum = wa + wb;
		if (wsum == 0) wsum = 1;
		if (dq != 0) begin
			eneg = dist_val < len;
			kk = eneg ? k_compress : k_stretch;
			emag = eneg ? len - dist_val : dist_val - len;
			g = (kk * emag) >> STIFF_W;
			ra = (wa << FB) / wsum;
			rb = (wb << FB) / wsum;
			ta = (g * ra) >> FB;
			tb = (g * rb) >> FB;
			for (int i = 0; i < 3; i++) begin
				ca = ta * q[i] / dq;
				cb = tb * q[i] / dq;
				if (eneg == neg[i]) begin
					da[i] = -longint'(ca);
					db[i] = longint'(cb);
				end else begin
					da[i] = longint'(ca);
					db[i] = -longint'(cb);
				end
			end
		end
		add_correction(it.va, da, 1'b0);
		add_correction(it.vb, db, 1'b1);
	endfunction

	// result checker
	always @(posedge clk) begin
		acc_update_t got, want;
		if (m_tvalid && m_tready) begin
			got = '{idx: m_tdata[9:0], ax: m_tdata[41:10], ay: m_tdata[73:42],
				az: m_tdata[105:74], last: m_tlast};
			if (pending_updates.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result idx=%0d x=%h y=%h z=%h last=%b",
						got.idx, got.ax, got.ay, got.az, got.last);
			end else begin
				want = pending_updates.pop_front();
				if (got != want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp idx=%0d x=%h y=%h z=%h last=%b, got idx=%0d x=%h y=%h z=%h last=%b",
							want.idx, want.ax, want.ay, want.az, want.last,
							got.idx, got.ax, got.ay, got.az, got.last);
				end
			end
		end
	end

	// receiver stall pattern, with an occasional long hold
	always @(posedge clk) begin
		int hold_left;
		int mode;
		int mode_left;
		bit hold_seen;
		if (hold_req && !hold_seen) begin
			hold_seen = 1'b1;
			hold_left = LONG_HOLD;
		end else if (!hold_req) begin
			hold_seen = 1'b0;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			if (mode_left <= 0) begin
				mode = $urandom_range(0, 2);
				mode_left = $urandom_range(20, 400);
			end
			mode_left--;
			case (mode)
				0: m_tready <= 1'b1;
				1: m_tready <= ($urandom_range(0, 1) == 1);
				default: m_tready <= ($urandom_range(0, 7) == 0);
			endcase
		end
	end

	// watchdog on cycles without any transaction
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			wdog <= 0;
		else
			wdog <= wdog + 1;
		if (wdog >= WDOG_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	task automatic send_constraint(constraint_item_t it);
		int gap;
		if (burst_left <= 0) begin
			gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 30);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 12);
		end
		s_tvalid <= 1'b1;
		s_tuser <= it.cmd;
		s_tdata <= {5'b0, it.vb, it.va, it.rest, it.imb, it.ima,
			it.pb[2], it.pb[1], it.pb[0], it.pa[2], it.pa[1], it.pa[0]};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		predict_corrections(it);
		burst_left--;
	endtask

	// pause the sender until every result is back, then let the block settle
	task automatic drain_results();
		@(posedge clk);
		s_tvalid <= 1'b0;
		burst_left = 0;
		while (pending_updates.size() != 0) @(posedge clk);
		repeat (IDLE_WAIT) @(posedge clk);
	endtask

	task automatic write_stiffness(bit [CFG_IDX_W-1:0] idx, bit [STIFF_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		if (idx == CFG_STRETCH) k_stretch = val;
		else if (idx == CFG_COMPRESS) k_compress = val;
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	function automatic bit [POS_W-1:0] rand_pos(bit wide);
		if (wide) return $urandom;
		return $urandom_range(0, 2097152) - 1048576;
	endfunction

	function automatic bit [MASS_W-1:0] rand_mass();
		case ($urandom_range(0, 7))
			0: return '1;
			1: return 0;
			2, 3: return $urandom_range(0, 262144);
			default: return $urandom;
		endcase
	endfunction

	function automatic constraint_item_t rand_constraint();
		constraint_item_t it;
		bit wide;
		wide = ($urandom_range(0, 3) == 0);
		it.cmd = ($urandom_range(0, 9) == 0) ? CMD_CLEAR : CMD_SOLVE;
		for (int i = 0; i < 3; i++) begin
			it.pa[i] = rand_pos(wide);
			it.pb[i] = rand_pos(wide);
		end
		it.ima = rand_mass();
		it.imb = rand_mass();
		it.rest = ($urandom_range(0, 2) == 0) ? LEN_W'($urandom) :
			LEN_W'($urandom_range(0, 3000000));
		it.va = ($urandom_range(0, 1) == 0) ? IDX_W'($urandom_range(0, 15)) : IDX_W'($urandom);
		it.vb = ($urandom_range(0, 1) == 0) ? IDX_W'($urandom_range(0, 15)) : IDX_W'($urandom);
		return it;
	endfunction

	function automatic constraint_item_t make_constraint(int ax, int ay, int az, int bx, int by,
			int bz, bit [31:0] ima, bit [31:0] imb, bit [30:0] rest, int va, int vb);
		constraint_item_t it;
		it.cmd = CMD_SOLVE;
		it.pa = '{ax, ay, az};
		it.pb = '{bx, by, bz};
		it.ima = ima;
		it.imb = imb;
		it.rest = rest;
		it.va = IDX_W'(va);
		it.vb = IDX_W'(vb);
		return it;
	endfunction

	task automatic test_directed();
		constraint_item_t it;
		// stretched, equal masses
		send_constraint(make_constraint(65536 * 3, 0, 0, 0, 0, 0, 65536, 65536, 65536, 1, 2));
		// coincident vertices
		send_constraint(make_constraint(1000, -5, 7, 1000, -5, 7, 65536, 65536, 65536, 3, 4));
		// same entry for both ends
		send_constraint(make_constraint(0, 65536 * 5, 0, 0, 0, 65536, 65536, 131072, 0, 5, 5));
		// both infinite masses, weight sum forced to one
		send_constraint(make_constraint(200000, 300000, -400000, 0, 0, 0, '1, '1, 10, 6, 7));
		// one infinite, one zero mass
		send_constraint(make_constraint(-70000, 1, 2, 70000, 3, 4, '1, 0, 0, 6, 7));
		// one side infinite
		send_constraint(make_constraint(-70000, 1, 2, 70000, 3, 4, '1, 65536, 0, 6, 7));
		// largest differences, forces the shift
		for (int i = 0; i < 3; i++)
			send_constraint(make_constraint(32'h7fffffff, 32'h80000000, 32'h7fffffff,
				32'h80000000, 32'h7fffffff, 32'h80000000, '1 - 1, '1 - 1, '1, 1023, 0));
		// compressed with maximal rest length
		send_constraint(make_constraint(10, 20, 30, -10, -20, -30, 65536, 65536, '1, 8, 9));
		// repeated full-range stretches accumulating on one entry
		for (int i = 0; i < 6; i++)
			send_constraint(make_constraint(32'h80000000, 32'h80000000, 32'h80000000,
				32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'hfffffffe, 1, 0, 10, 11));
		// clear items, all with stray fields set
		it = make_constraint(-1, -1, -1, -1, -1, -1, '1, '1, '1, 10, 1023);
		it.cmd = CMD_CLEAR;
		send_constraint(it);
		it.va = 10'd1023;
		send_constraint(it);
		it.va = 10'd0;
		send_constraint(it);
		send_constraint(make_constraint(1, 0, 0, 0, 0, 0, 65536, 65536, 0, 10, 10));
		drain_results();
	endtask

	task automatic test_stiffness_extremes();
		write_stiffness(CFG_STRETCH, 16'hffff);
		write_stiffness(CFG_COMPRESS, 16'hffff);
		write_stiffness(8'hff, 16'h1234);
		send_constraint(make_constraint(10, 20, 30, -10, -20, -30, 65536, 65536, '1, 12, 13));
		send_constraint(make_constraint(65536 * 9, 7, 7, 0, 0, 0, 65536, 65536, 100, 12, 13));
		drain_results();
		write_stiffness(CFG_STRETCH, 16'd0);
		write_stiffness(CFG_COMPRESS, 16'd0);
		send_constraint(make_constraint(65536 * 9, 7, 7, 0, 0, 0, 65536, 65536, 100, 12, 13));
		send_constraint(make_constraint(10, 20, 30, -10, -20, -30, 65536, 65536, '1, 12, 13));
		drain_results();
	endtask

	task automatic test_random_phases();
		for (int p = 0; p < 5; p++) begin
			case (p)
				0: begin
					write_stiffness(CFG_STRETCH, STRETCH_RST);
					write_stiffness(CFG_COMPRESS, COMPRESS_RST);
				end
				1: begin
					write_stiffness(CFG_STRETCH, 16'hffff);
					write_stiffness(CFG_COMPRESS, 16'hffff);
				end
				2: begin
					write_stiffness(CFG_STRETCH, 16'd0);
					write_stiffness(CFG_COMPRESS, 16'h8000);
				end
				default: begin
					write_stiffness(CFG_STRETCH, STIFF_W'($urandom));
					write_stiffness(CFG_COMPRESS, STIFF_W'($urandom));
					write_stiffness(CFG_IDX_W'($urandom_range(2, 255)), STIFF_W'($urandom));
				end
			endcase
			repeat (290) send_constraint(rand_constraint());
			drain_results();
		end
	endtask

	task automatic test_output_backpressure();
		hold_req = 1'b1;
		repeat (30) send_constraint(rand_constraint());
		drain_results();
		hold_req = 1'b0;
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		test_directed();
		test_stiffness_extremes();
		test_output_backpressure();
		test_random_phases();
		drain_results();
		if (mismatches == 0 && pending_updates.size() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
`default_nettype wire
